[hw/rtl/btape_pkg.sv]
// shared types, constants and microprogram for the bracket tape interpreter
// no dependencies; imported by btape_seq and bracket_tape_interpreter

package btape_pkg;

    localparam int TAPE_DEPTH = 4096;
    localparam int PROG_DEPTH = 4096;

    localparam int TP_W   = $clog2(TAPE_DEPTH);
    localparam int PA_W   = $clog2(PROG_DEPTH);
    localparam int PLEN_W = $clog2(PROG_DEPTH + 1);
    localparam int UPC_W  = 5;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_END       = 3'd1;
    localparam logic [2:0] ST_WAIT      = 3'd2;
    localparam logic [2:0] ST_UNMATCHED = 3'd3;
    localparam logic [2:0] ST_FULL      = 3'd4;

    localparam logic [7:0] CH_RIGHT = 8'h3E;
    localparam logic [7:0] CH_LEFT  = 8'h3C;
    localparam logic [7:0] CH_INC   = 8'h2B;
    localparam logic [7:0] CH_DEC   = 8'h2D;
    localparam logic [7:0] CH_PUT   = 8'h2E;
    localparam logic [7:0] CH_GET   = 8'h2C;
    localparam logic [7:0] CH_OPEN  = 8'h5B;
    localparam logic [7:0] CH_CLOSE = 8'h5D;

    typedef struct packed {
        logic       operation;
        logic [7:0] prog_char;
        logic       first_char;
        logic [7:0] in_byte;
        logic       in_valid;
    } item_t;

    typedef struct packed {
        logic [2:0] status;
        logic [7:0] out_byte;
        logic       out_valid;
    } result_t;

    typedef logic [UPC_W-1:0] upc_t;

    localparam upc_t U_IDLE      = 5'd0;
    localparam upc_t U_DISPATCH  = 5'd1;
    localparam upc_t U_LOAD      = 5'd2;
    localparam upc_t U_RIGHT     = 5'd3;
    localparam upc_t U_LEFT      = 5'd4;
    localparam upc_t U_INC       = 5'd5;
    localparam upc_t U_DEC       = 5'd6;
    localparam upc_t U_PUT       = 5'd7;
    localparam upc_t U_GET       = 5'd8;
    localparam upc_t U_WAIT      = 5'd9;
    localparam upc_t U_ADV       = 5'd10;
    localparam upc_t U_FWD_INIT  = 5'd11;
    localparam upc_t U_FWD_TEST  = 5'd12;
    localparam upc_t U_FWD_EVAL  = 5'd13;
    localparam upc_t U_FWD_DONE  = 5'd14;
    localparam upc_t U_BWD_INIT  = 5'd15;
    localparam upc_t U_BWD_TEST  = 5'd16;
    localparam upc_t U_BWD_READ  = 5'd17;
    localparam upc_t U_BWD_EVAL  = 5'd18;
    localparam upc_t U_BWD_DONE  = 5'd19;
    localparam upc_t U_UNMATCHED = 5'd20;
    localparam upc_t U_END       = 5'd21;
    localparam upc_t U_STOP_RPT  = 5'd22;
    localparam upc_t U_EMIT      = 5'd31;

    typedef enum logic [3:0] {
        C_NEVER,
        C_ALWAYS,
        C_NO_ITEM,
        C_DISPATCH,
        C_FWD_OUT,
        C_FWD_MORE,
        C_IDX_ZERO,
        C_BWD_MORE,
        C_OUT_BUSY
    } cond_t;

    typedef enum logic [4:0] {
        A_NONE,
        A_LOAD,
        A_RIGHT,
        A_LEFT,
        A_INC,
        A_DEC,
        A_PUT,
        A_GET,
        A_WAIT,
        A_ADV,
        A_FWD_INIT,
        A_FWD_EVAL,
        A_SP_SCAN,
        A_BWD_INIT,
        A_IDX_DEC,
        A_BWD_EVAL,
        A_UNMATCHED,
        A_END,
        A_STOP_RPT,
        A_EMIT
    } act_t;

    typedef struct packed {
        cond_t cond;
        upc_t  target;
        act_t  act;
        logic  scan_sel;
        logic  take;
    } ctrl_word_t;

    typedef struct packed {
        logic no_item;
        logic fwd_out;
        logic fwd_more;
        logic idx_zero;
        logic bwd_more;
        logic out_busy;
        upc_t disp_target;
    } seq_flags_t;

    function automatic ctrl_word_t mk_word(input cond_t c, input upc_t t, input act_t a,
                                           input logic sel, input logic take);
        ctrl_word_t w;
        w.cond     = c;
        w.target   = t;
        w.act      = a;
        w.scan_sel = sel;
        w.take     = take;
        return w;
    endfunction

    function automatic ctrl_word_t ucode_rom(input upc_t addr);
        ctrl_word_t w;
        unique case (addr)
            U_IDLE:      w = mk_word(C_NO_ITEM,  U_IDLE,     A_NONE,      1'b0, 1'b1);
            U_DISPATCH:  w = mk_word(C_DISPATCH, U_IDLE,     A_NONE,      1'b0, 1'b0);
            U_LOAD:      w = mk_word(C_ALWAYS,   U_EMIT,     A_LOAD,      1'b0, 1'b0);
            U_RIGHT:     w = mk_word(C_ALWAYS,   U_EMIT,     A_RIGHT,     1'b0, 1'b0);
            U_LEFT:      w = mk_word(C_ALWAYS,   U_EMIT,     A_LEFT,      1'b0, 1'b0);
            U_INC:       w = mk_word(C_ALWAYS,   U_EMIT,     A_INC,       1'b0, 1'b0);
            U_DEC:       w = mk_word(C_ALWAYS,   U_EMIT,     A_DEC,       1'b0, 1'b0);
            U_PUT:       w = mk_word(C_ALWAYS,   U_EMIT,     A_PUT,       1'b0, 1'b0);
            U_GET:       w = mk_word(C_ALWAYS,   U_EMIT,     A_GET,       1'b0, 1'b0);
            U_WAIT:      w = mk_word(C_ALWAYS,   U_EMIT,     A_WAIT,      1'b0, 1'b0);
            U_ADV:       w = mk_word(C_ALWAYS,   U_EMIT,     A_ADV,       1'b0, 1'b0);
            U_FWD_INIT:  w = mk_word(C_NEVER,    U_IDLE,     A_FWD_INIT,  1'b0, 1'b0);
            U_FWD_TEST:  w = mk_word(C_FWD_OUT,  U_UNMATCHED, A_NONE,     1'b1, 1'b0);
            U_FWD_EVAL:  w = mk_word(C_FWD_MORE, U_FWD_TEST, A_FWD_EVAL,  1'b1, 1'b0);
            U_FWD_DONE:  w = mk_word(C_ALWAYS,   U_EMIT,     A_SP_SCAN,   1'b0, 1'b0);
            U_BWD_INIT:  w = mk_word(C_NEVER,    U_IDLE,     A_BWD_INIT,  1'b0, 1'b0);
            U_BWD_TEST:  w = mk_word(C_IDX_ZERO, U_UNMATCHED, A_IDX_DEC,  1'b1, 1'b0);
            U_BWD_READ:  w = mk_word(C_NEVER,    U_IDLE,     A_NONE,      1'b1, 1'b0);
            U_BWD_EVAL:  w = mk_word(C_BWD_MORE, U_BWD_TEST, A_BWD_EVAL,  1'b1, 1'b0);
            U_BWD_DONE:  w = mk_word(C_ALWAYS,   U_EMIT,     A_SP_SCAN,   1'b0, 1'b0);
            U_UNMATCHED: w = mk_word(C_ALWAYS,   U_EMIT,     A_UNMATCHED, 1'b0, 1'b0);
            U_END:       w = mk_word(C_ALWAYS,   U_EMIT,     A_END,       1'b0, 1'b0);
            U_STOP_RPT:  w = mk_word(C_ALWAYS,   U_EMIT,     A_STOP_RPT,  1'b0, 1'b0);
            U_EMIT:      w = mk_word(C_OUT_BUSY, U_EMIT,     A_EMIT,      1'b0, 1'b0);
            default:     w = mk_word(C_ALWAYS,   U_IDLE,     A_NONE,      1'b0, 1'b0);
        endcase
        return w;
    endfunction

    function automatic upc_t dispatch_map(input logic is_load, input logic stopped,
                                          input logic at_end, input logic [7:0] cmd,
                                          input logic cell_zero, input logic byte_ok);
        upc_t t;
        if (is_load) begin
            t = U_LOAD;
        end else if (stopped) begin
            t = U_STOP_RPT;
        end else if (at_end) begin
            t = U_END;
        end else begin
            unique case (cmd)
                CH_RIGHT: t = U_RIGHT;
                CH_LEFT:  t = U_LEFT;
                CH_INC:   t = U_INC;
                CH_DEC:   t = U_DEC;
                CH_PUT:   t = U_PUT;
                CH_GET:   t = byte_ok ? U_GET : U_WAIT;
                CH_OPEN:  t = cell_zero ? U_FWD_INIT : U_ADV;
                CH_CLOSE: t = U_BWD_INIT;
                default:  t = U_ADV;
            endcase
        end
        return t;
    endfunction

endpackage

[hw/rtl/btape_ram.sv]
// generic single write port, single read port ram with registered read data
// no dependencies

module btape_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[hw/rtl/btape_seq.sv]
// microprogram sequencer: step counter, control rom and conditional jumps
// depends on btape_pkg

module btape_seq import btape_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  seq_flags_t flags,
    output ctrl_word_t ctrl
);

    upc_t upc_reg;
    upc_t upc_next;
    upc_t target;
    logic taken;

    assign ctrl = ucode_rom(upc_reg);

    always_comb
    begin
        target = ctrl.target;
        unique case (ctrl.cond)
            C_NEVER:    taken = 1'b0;
            C_ALWAYS:   taken = 1'b1;
            C_NO_ITEM:  taken = flags.no_item;
            C_DISPATCH:
            begin
                taken  = 1'b1;
                target = flags.disp_target;
            end
            C_FWD_OUT:  taken = flags.fwd_out;
            C_FWD_MORE: taken = flags.fwd_more;
            C_IDX_ZERO: taken = flags.idx_zero;
            C_BWD_MORE: taken = flags.bwd_more;
            C_OUT_BUSY: taken = flags.out_busy;
            default:    taken = 1'b0;
        endcase
        upc_next = taken ? target : upc_reg + UPC_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg <= U_IDLE;
        end
        else
        begin
            upc_reg <= upc_next;
        end
    end

endmodule

[hw/rtl/bracket_tape_interpreter.sv]
// bracket tape interpreter top level: datapath, tape and program rams, sequencer
// each item is taken in the idle step, then walks dispatch, its handler and the emit step of
// the microprogram; loads and plain commands take this path, '[' on a zero cell adds a forward
// scan char by char and ']' a backward scan, ending in the unmatched step when the match is
// missing; a stalled result holds off the next transfer
// reset: clears every tape cell with item_ready low; uses btape_pkg, btape_seq, btape_ram

module bracket_tape_interpreter import btape_pkg::*; (
    input  logic    clk,
    input  logic    rst_n,
    input  logic    item_valid,
    output logic    item_ready,
    input  item_t   item,
    output logic    result_valid,
    input  logic    result_ready,
    output result_t result
);

    ctrl_word_t ctrl;
    seq_flags_t flags;

    item_t   item_reg;
    result_t res_reg;
    result_t res_next;
    result_t result_reg;
    logic    result_valid_reg;

    logic [TP_W-1:0]   tp_reg;
    logic [TP_W-1:0]   tp_next;
    logic [PLEN_W-1:0] sp_reg;
    logic [PLEN_W-1:0] sp_next;
    logic [PLEN_W-1:0] plen_reg;
    logic [PLEN_W-1:0] plen_next;
    logic              stopped_reg;
    logic              stopped_next;
    logic [PLEN_W-1:0] scan_reg;
    logic [PLEN_W-1:0] scan_next;
    logic [PLEN_W-1:0] depth_reg;
    logic [PLEN_W-1:0] depth_next;
    logic              clear_active_reg;
    logic [TP_W-1:0]   clear_addr_reg;

    logic              item_xfer;
    logic              out_busy;
    logic              at_end;
    logic [PLEN_W-1:0] eff_len;

    logic              prog_we;
    logic [PA_W-1:0]   prog_raddr;
    logic [7:0]        prog_rdata;
    logic              cell_we;
    logic [7:0]        cell_wdata;
    logic              tape_we;
    logic [TP_W-1:0]   tape_waddr;
    logic [7:0]        tape_wdata;
    logic [7:0]        tape_rdata;

    assign item_ready   = ctrl.take && !clear_active_reg;
    assign item_xfer    = item_valid && item_ready;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;
    assign out_busy     = result_valid_reg && !result_ready;
    assign at_end       = sp_reg >= plen_reg;
    assign eff_len      = item_reg.first_char ? '0 : plen_reg;

    assign flags.no_item     = !item_xfer;
    assign flags.fwd_out     = scan_reg >= plen_reg;
    assign flags.fwd_more    = !(prog_rdata == CH_CLOSE && depth_reg == PLEN_W'(1));
    assign flags.idx_zero    = scan_reg == '0;
    assign flags.bwd_more    = !(prog_rdata == CH_OPEN && depth_reg == PLEN_W'(1));
    assign flags.out_busy    = out_busy;
    assign flags.disp_target = dispatch_map(!item_reg.operation, stopped_reg, at_end,
                                            prog_rdata, tape_rdata == 8'd0,
                                            item_reg.in_valid);

    btape_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .flags (flags),
        .ctrl  (ctrl)
    );

    assign prog_raddr = ctrl.scan_sel ? scan_reg[PA_W-1:0] : sp_reg[PA_W-1:0];

    btape_ram #(
        .WIDTH (8),
        .DEPTH (PROG_DEPTH)
    ) u_prog_ram (
        .clk   (clk),
        .we    (prog_we),
        .waddr (eff_len[PA_W-1:0]),
        .wdata (item_reg.prog_char),
        .raddr (prog_raddr),
        .rdata (prog_rdata)
    );

    assign tape_we    = clear_active_reg || cell_we;
    assign tape_waddr = clear_active_reg ? clear_addr_reg : tp_reg;
    assign tape_wdata = clear_active_reg ? 8'd0 : cell_wdata;

    btape_ram #(
        .WIDTH (8),
        .DEPTH (TAPE_DEPTH)
    ) u_tape_ram (
        .clk   (clk),
        .we    (tape_we),
        .waddr (tape_waddr),
        .wdata (tape_wdata),
        .raddr (tp_reg),
        .rdata (tape_rdata)
    );

    always_comb
    begin
        tp_next      = tp_reg;
        sp_next      = sp_reg;
        plen_next    = plen_reg;
        stopped_next = stopped_reg;
        scan_next    = scan_reg;
        depth_next   = depth_reg;
        res_next     = res_reg;
        prog_we      = 1'b0;
        cell_we      = 1'b0;
        cell_wdata   = tape_rdata;
        unique case (ctrl.act) inside
            A_NONE, A_EMIT:
            begin
            end
            A_LOAD:
            begin
                if (item_reg.first_char)
                begin
                    sp_next      = '0;
                    tp_next      = '0;
                    stopped_next = 1'b0;
                end
                res_next = '{status: ST_OK, out_byte: 8'd0, out_valid: 1'b0};
                if (eff_len == PLEN_W'(PROG_DEPTH))
                begin
                    plen_next       = eff_len;
                    res_next.status = ST_FULL;
                end
                else
                begin
                    prog_we   = 1'b1;
                    plen_next = eff_len + PLEN_W'(1);
                end
            end
            A_RIGHT:
            begin
                tp_next  = (tp_reg == TP_W'(TAPE_DEPTH - 1)) ? '0 : tp_reg + TP_W'(1);
                sp_next  = sp_reg + PLEN_W'(1);
                res_next = '{status: ST_OK, out_byte: 8'd0, out_valid: 1'b0};
            end
            A_LEFT:
            begin
                tp_next  = (tp_reg == '0) ? TP_W'(TAPE_DEPTH - 1) : tp_reg - TP_W'(1);
                sp_next  = sp_reg + PLEN_W'(1);
                res_next = '{status: ST_OK, out_byte: 8'd0, out_valid: 1'b0};
            end
            A_INC:
            begin
                cell_we    = 1'b1;
                cell_wdata = (tape_rdata == 8'hFF) ? tape_rdata : tape_rdata + 8'd1;
                sp_next    = sp_reg + PLEN_W'(1);
                res_next   = '{status: ST_OK, out_byte: 8'd0, out_valid: 1'b0};
            end
            A_DEC:
            begin
                cell_we    = 1'b1;
                cell_wdata = (tape_rdata == 8'd0) ? tape_rdata : tape_rdata - 8'd1;
                sp_next    = sp_reg + PLEN_W'(1);
                res_next   = '{status: ST_OK, out_byte: 8'd0, out_valid: 1'b0};
            end
            A_PUT:
            begin
                sp_next  = sp_reg + PLEN_W'(1);
                res_next = '{status: ST_OK, out_byte: tape_rdata, out_valid: 1'b1};
            end
            A_GET:
            begin
                cell_we    = 1'b1;
                cell_wdata = item_reg.in_byte;
                sp_next    = sp_reg + PLEN_W'(1);
                res_next   = '{status: ST_OK, out_byte: 8'd0, out_valid: 1'b0};
            end
            A_WAIT:
            begin
                res_next = '{status: ST_WAIT, out_byte: 8'd0, out_valid: 1'b0};
            end
            A_ADV:
            begin
                sp_next  = sp_reg + PLEN_W'(1);
                res_next = '{status: ST_OK, out_byte: 8'd0, out_valid: 1'b0};
            end
            A_FWD_INIT:
            begin
                scan_next  = sp_reg + PLEN_W'(1);
                depth_next = PLEN_W'(1);
            end
            A_FWD_EVAL:
            begin
                if (prog_rdata == CH_OPEN)
                begin
                    depth_next = depth_reg + PLEN_W'(1);
                end
                else if (prog_rdata == CH_CLOSE)
                begin
                    depth_next = depth_reg - PLEN_W'(1);
                end
                scan_next = scan_reg + PLEN_W'(1);
            end
            A_SP_SCAN:
            begin
                sp_next  = scan_reg;
                res_next = '{status: ST_OK, out_byte: 8'd0, out_valid: 1'b0};
            end
            A_BWD_INIT:
            begin
                scan_next  = sp_reg;
                depth_next = PLEN_W'(1);
            end
            A_IDX_DEC:
            begin
                scan_next = scan_reg - PLEN_W'(1);
            end
            A_BWD_EVAL:
            begin
                if (prog_rdata == CH_CLOSE)
                begin
                    depth_next = depth_reg + PLEN_W'(1);
                end
                else if (prog_rdata == CH_OPEN)
                begin
                    depth_next = depth_reg - PLEN_W'(1);
                end
            end
            A_UNMATCHED:
            begin
                stopped_next = 1'b1;
                res_next     = '{status: ST_UNMATCHED, out_byte: 8'd0, out_valid: 1'b0};
            end
            A_END:
            begin
                stopped_next = 1'b1;
                res_next     = '{status: ST_END, out_byte: 8'd0, out_valid: 1'b0};
            end
            A_STOP_RPT:
            begin
                res_next = '{status: at_end ? ST_END : ST_UNMATCHED, out_byte: 8'd0,
                             out_valid: 1'b0};
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tp_reg           <= '0;
            sp_reg           <= '0;
            plen_reg         <= '0;
            stopped_reg      <= 1'b0;
            result_valid_reg <= 1'b0;
            clear_active_reg <= 1'b1;
            clear_addr_reg   <= '0;
        end
        else
        begin
            tp_reg      <= tp_next;
            sp_reg      <= sp_next;
            plen_reg    <= plen_next;
            stopped_reg <= stopped_next;
            if (ctrl.act == A_EMIT && !out_busy)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (result_valid_reg && result_ready)
            begin
                result_valid_reg <= 1'b0;
            end
            if (clear_active_reg)
            begin
                if (clear_addr_reg == TP_W'(TAPE_DEPTH - 1))
                begin
                    clear_active_reg <= 1'b0;
                end
                else
                begin
                    clear_addr_reg <= clear_addr_reg + TP_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_xfer)
        begin
            item_reg <= item;
        end
        if (ctrl.act == A_EMIT && !out_busy)
        begin
            result_reg <= res_reg;
        end
        res_reg   <= res_next;
        scan_reg  <= scan_next;
        depth_reg <= depth_next;
    end

`ifndef SYNTH
    a_no_result_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        clear_active_reg |-> !result_valid)
        else $error("result offered during tape clearing");

    a_one_item_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        item_xfer |=> !item_ready)
        else $error("second item taken while one is at work");

    a_plen_bound: assert property (@(posedge clk) disable iff (!rst_n)
        plen_reg <= PLEN_W'(PROG_DEPTH))
        else $error("program length beyond store depth");

    a_tp_bound: assert property (@(posedge clk) disable iff (!rst_n)
        tp_reg <= TP_W'(TAPE_DEPTH - 1))
        else $error("data pointer beyond tape");

    a_byte_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.out_valid) |-> (result.status == ST_OK))
        else $error("output byte with non-ok status");
`endif

endmodule
